// ----- design/tgarle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  localparam int BYTE_W  = 8;
  localparam int COLOR_W = 32;
  localparam int FIRST_W = 24;
  localparam int COUNT_W = 8;
  localparam int BPP_W   = 3;
  localparam int IMG_W   = 25;
  localparam int CFG_W   = 25;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_PIXELS    = 1'b1;

  localparam logic [BPP_W-1:0] BPP_RESET  = 3'd4;
  localparam logic [BPP_W-1:0] BPP_THREE  = 3'd3;
  localparam logic [IMG_W-1:0] IMG_RESET  = 25'd1;

  localparam logic [BYTE_W-1:0] RUN_MASK   = 8'h80;
  localparam logic [BYTE_W-1:0] COUNT_MASK = 8'h7F;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PIXEL,
    PH_FINISHED
  } phase_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [FIRST_W-1:0] first_pixel;
    logic [COUNT_W-1:0] repeat_count;
    logic               status;
    logic               image_done;
  } result_t;

endpackage

// ----- design/tgarle_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgarle_front
// Byte classifier and packet decoder: parses headers, gathers pixel bytes and
// produces one result per completed pixel or oversized packet.
// ----------------------------------------------------------------------------
module tgarle_front #(
  parameter int MAX_PIXELS_LOG2 = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tgarle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tgarle_pkg::CFG_W-1:0]        cfg_data,
  input  logic                                take,
  input  logic [tgarle_pkg::BYTE_W-1:0]       data_byte,
  output logic                                push,
  output tgarle_pkg::result_t                 res
);

  localparam int RW = MAX_PIXELS_LOG2 + 1;
  localparam int IW = MAX_PIXELS_LOG2;
  localparam int EW = (RW > tgarle_pkg::IMG_W) ? RW : tgarle_pkg::IMG_W;

  logic [tgarle_pkg::BPP_W-1:0]   bpp;
  logic [tgarle_pkg::IMG_W-1:0]   img;
  tgarle_pkg::phase_t             phase, phase_next;
  logic                           run_packet, run_packet_next;
  logic [tgarle_pkg::COUNT_W-1:0] left, left_next;
  logic [1:0]                     bip, bip_next;
  logic [tgarle_pkg::COLOR_W-1:0] color, color_next;
  logic [RW-1:0]                  remaining, remaining_next;
  logic [IW-1:0]                  pix_index, pix_index_next;

  logic [tgarle_pkg::IMG_W-1:0]   img_sel;
  logic [EW-1:0]                  img_ext, cap_ext, init_ext;
  logic [RW-1:0]                  remaining_init;
  logic [tgarle_pkg::COUNT_W-1:0] hcount, pcount;
  logic                           oversize, complete, done;
  logic [1:0]                     size_code, bip_inc;
  logic [tgarle_pkg::COLOR_W-1:0] color_acc;
  logic [RW-1:0]                  rem_sub;
  logic [tgarle_pkg::COUNT_W-1:0] left_sub;

  assign img_sel = (cfg_index == tgarle_pkg::REG_IMAGE_PIXELS)
                   ? cfg_data[tgarle_pkg::IMG_W-1:0] : img;
  assign img_ext = EW'(img_sel);
  assign cap_ext = EW'(1) << MAX_PIXELS_LOG2;
  assign init_ext = (img_ext > cap_ext) ? cap_ext : img_ext;
  assign remaining_init = RW'(init_ext);

  assign hcount    = (data_byte & tgarle_pkg::COUNT_MASK) + 8'd1;
  assign oversize  = RW'(hcount) > remaining;
  assign size_code = (bpp == tgarle_pkg::BPP_THREE) ? 2'd3 : 2'd0;
  assign bip_inc   = bip + 2'd1;
  assign complete  = (bip_inc == size_code);
  assign color_acc = color | (tgarle_pkg::COLOR_W'(data_byte) << {bip, 3'b000});
  assign pcount    = run_packet ? left : 8'd1;
  assign rem_sub   = remaining - RW'(pcount);
  assign left_sub  = left - pcount;
  assign done      = (rem_sub == '0);

  always_comb begin
    phase_next = phase;
    case (phase)
      tgarle_pkg::PH_HEADER: begin
        if (take) begin
          phase_next = oversize ? tgarle_pkg::PH_FINISHED : tgarle_pkg::PH_PIXEL;
        end
      end
      tgarle_pkg::PH_PIXEL: begin
        if (take && complete) begin
          if (done) begin
            phase_next = tgarle_pkg::PH_FINISHED;
          end else if (left_sub == '0) begin
            phase_next = tgarle_pkg::PH_HEADER;
          end
        end
      end
      tgarle_pkg::PH_FINISHED: phase_next = tgarle_pkg::PH_FINISHED;
      default: phase_next = tgarle_pkg::PH_FINISHED;
    endcase
  end

  always_comb begin
    push            = 1'b0;
    res             = '0;
    run_packet_next = run_packet;
    left_next       = left;
    bip_next        = bip;
    color_next      = color;
    remaining_next  = remaining;
    pix_index_next  = pix_index;
    res.first_pixel = tgarle_pkg::FIRST_W'(pix_index);
    case (phase)
      tgarle_pkg::PH_HEADER: begin
        if (take) begin
          if (oversize) begin
            push             = 1'b1;
            res.repeat_count = hcount;
            res.status       = 1'b1;
            res.image_done   = 1'b1;
          end else begin
            run_packet_next = (data_byte & tgarle_pkg::RUN_MASK) != '0;
            left_next       = hcount;
            bip_next        = 2'd0;
            color_next      = '0;
          end
        end
      end
      tgarle_pkg::PH_PIXEL: begin
        if (take) begin
          if (complete) begin
            push             = 1'b1;
            res.pixel_color  = color_acc;
            res.repeat_count = pcount;
            res.image_done   = done;
            remaining_next   = rem_sub;
            pix_index_next   = pix_index + IW'(pcount);
            left_next        = left_sub;
            bip_next         = 2'd0;
            color_next       = '0;
          end else begin
            bip_next   = bip_inc;
            color_next = color_acc;
          end
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp        <= tgarle_pkg::BPP_RESET;
      img        <= tgarle_pkg::IMG_RESET;
      phase      <= tgarle_pkg::PH_HEADER;
      run_packet <= 1'b0;
      left       <= '0;
      bip        <= '0;
      color      <= '0;
      remaining  <= RW'(1);
      pix_index  <= '0;
    end else if (cfg_write) begin
      if (cfg_index == tgarle_pkg::REG_BYTES_PER_PIXEL) begin
        bpp <= cfg_data[tgarle_pkg::BPP_W-1:0];
      end else begin
        img <= cfg_data[tgarle_pkg::IMG_W-1:0];
      end
      phase      <= (remaining_init == '0) ? tgarle_pkg::PH_FINISHED
                                            : tgarle_pkg::PH_HEADER;
      run_packet <= 1'b0;
      left       <= '0;
      bip        <= '0;
      color      <= '0;
      remaining  <= remaining_init;
      pix_index  <= '0;
    end else begin
      phase      <= phase_next;
      run_packet <= run_packet_next;
      left       <= left_next;
      bip        <= bip_next;
      color      <= color_next;
      remaining  <= remaining_next;
      pix_index  <= pix_index_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (phase == tgarle_pkg::PH_PIXEL) |-> (RW'(left) <= remaining && left != '0))
    else $error("packet pixels exceed image pixels left");

endmodule

// ----- design/tgarle_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgarle_queue
// Short result queue between the decoder and the output stage.
// ----------------------------------------------------------------------------
module tgarle_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tgarle_pkg::result_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output tgarle_pkg::result_t head_data
);

  localparam int PW = $clog2(tgarle_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(tgarle_pkg::QUEUE_DEPTH + 1);

  tgarle_pkg::result_t slots [tgarle_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(tgarle_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(tgarle_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(tgarle_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue underflow");

endmodule

// ----- design/tgarle_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgarle_back
// Output stage: drains the result queue into the registered result channel.
// ----------------------------------------------------------------------------
module tgarle_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  tgarle_pkg::result_t head_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output tgarle_pkg::result_t out_data
);

  assign pop = head_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= head_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.status || out_data.image_done))
    else $error("error result without image done");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.repeat_count != '0))
    else $error("zero repeat count");

endmodule

// ----- design/tga_rle_pixel_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// TGA run-length pixel decoder: one stream byte in, one result per pixel, run
// or oversized packet out.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   input    | in_valid / in_stall    | data_byte
//   output   | out_valid / out_stall  | pixel_color, first_pixel,
//            |                        | repeat_count, status, image_done
//   config   | cfg_write              | cfg_index, cfg_data
//
// One byte per cycle is accepted while in_stall is low; the decoder updates all
// packet state in the cycle of the transfer. Results pass through the queue
// into the output register. A two-entry queue decouples the decoder from the
// output register, so a stalled output fills the queue before in_stall rises.
// Synchronous reset restores bytes_per_pixel 4 and image_pixels 1.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top #(
  parameter int MAX_PIXELS_LOG2 = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tgarle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tgarle_pkg::CFG_W-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tgarle_pkg::BYTE_W-1:0]    data_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tgarle_pkg::COLOR_W-1:0]   pixel_color,
  output logic [tgarle_pkg::FIRST_W-1:0]   first_pixel,
  output logic [tgarle_pkg::COUNT_W-1:0]   repeat_count,
  output logic                             status,
  output logic                             image_done
);

  logic                take, push, full, pop, head_valid;
  tgarle_pkg::result_t res, head_data, out_data;

  assign in_stall = full;
  assign take     = in_valid && !full;

  tgarle_front #(
    .MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .data_byte (data_byte),
    .push      (push),
    .res       (res)
  );

  tgarle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (res),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  tgarle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign pixel_color  = out_data.pixel_color;
  assign first_pixel  = out_data.first_pixel;
  assign repeat_count = out_data.repeat_count;
  assign status       = out_data.status;
  assign image_done   = out_data.image_done;

endmodule
